### design/cpu_schedule_simulator_assert.svh
// Assertion macros shared by the checker.
`ifndef CPU_SCHEDULE_SIMULATOR_ASSERT_SVH
`define CPU_SCHEDULE_SIMULATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CSS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// Next-cycle implication.
`define CSS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

### design/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the CPU schedule simulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package css_pkg;
	localparam int MaxTasks = 32;
	localparam int IdxW     = $clog2(MaxTasks);
	localparam int CntW     = $clog2(MaxTasks + 1);
	localparam int TimeW    = 22;

	typedef enum logic [1:0] {
		POL_FCFS = 2'd0,
		POL_SJF  = 2'd1,
		POL_STCF = 2'd2,
		POL_RSVD = 2'd3
	} policy_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_SCAN,
		ST_PICK,
		ST_IDLEJMP,
		ST_RUN,
		ST_RSCAN,
		ST_ADV,
		ST_EMIT,
		ST_WAITOUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // store input word
		logic init_copy;   // copy burst to remaining at scan index
		logic scan_clr;    // clear scan accumulators
		logic scan_step;   // evaluate entry at scan index
		logic idle_jump;   // clock to earliest pending arrival
		logic seed;        // align clock to selected arrival, seed run length
		logic rscan_step;  // next-arrival scan for STCF
		logic advance;     // run selected task
		logic emit;        // load output register
		logic idx_clr;
		logic idx_inc;
		logic batch_clr;
	} css_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic idx_last;     // scan index is last stored task
		logic have_sel;     // a task was selected
		logic sel_done;     // selected task finishes on this run
		logic all_done;
		logic empty;        // no tasks stored
		logic out_busy;     // output register holds a word
	} css_stat_t;
endpackage

### design/css_ctrl.sv
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer: load, then scan-select / run loop, one result per completion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module css_ctrl
	import css_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  css_stat_t stat,
	output css_cmd_t  cmd
);
	state_t state_q, state_d;
	logic   jumped_q, jumped_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			jumped_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			jumped_q <= jumped_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		jumped_d = jumped_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				if (stat.empty) begin
					cmd.batch_clr = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					cmd.init_copy = 1'b1;
					cmd.idx_inc   = 1'b1;
					if (stat.idx_last) begin
						cmd.idx_clr  = 1'b1;
						cmd.scan_clr = 1'b1;
						jumped_d     = 1'b0;
						state_d      = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (stat.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_PICK;
				end
			end
			ST_PICK: begin
				if (stat.have_sel) begin
					cmd.scan_clr = 1'b1;
					cmd.seed     = 1'b1;
					state_d      = ST_RSCAN;
				end else if (!jumped_q) begin
					state_d = ST_IDLEJMP;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_IDLEJMP: begin
				cmd.idle_jump = 1'b1;
				cmd.scan_clr  = 1'b1;
				jumped_d      = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_RSCAN: begin
				cmd.rscan_step = 1'b1;
				cmd.idx_inc    = 1'b1;
				if (stat.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_ADV;
				end
			end
			ST_ADV: begin
				cmd.advance = 1'b1;
				if (stat.sel_done) state_d = ST_EMIT;
				else begin
					cmd.scan_clr = 1'b1;
					jumped_d     = 1'b0;
					state_d      = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_WAITOUT;
				end
			end
			ST_WAITOUT: begin
				if (stat.all_done) begin
					cmd.batch_clr = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					cmd.scan_clr = 1'b1;
					jumped_d     = 1'b0;
					state_d      = ST_SCAN;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end
endmodule

### design/css_datapath.sv
// ----------------------------------------------------------------------------
// css_datapath
// Task stores, selection scan, simulated clock and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module css_datapath
	import css_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  css_cmd_t          cmd,
	output css_stat_t         stat,
	input  logic [1:0]        policy,
	input  logic [7:0]        task_id,
	input  logic [15:0]       arrival_time,
	input  logic [15:0]       burst_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        done_task_id,
	output logic [TimeW-1:0]  waiting_time,
	output logic [TimeW-1:0]  turnaround_time,
	output logic              last_result,
	output logic              overflow
);
	logic [7:0]  id_mem  [MaxTasks];
	logic [15:0] arr_mem [MaxTasks];
	logic [15:0] bur_mem [MaxTasks];
	logic [15:0] rem_mem [MaxTasks];

	logic [MaxTasks-1:0] fin_q;
	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     ndone_q;
	logic [IdxW-1:0]     idx_q;
	logic [TimeW-1:0]    clk_q;
	logic                drop_q;

	logic                sel_v_q;
	logic [IdxW-1:0]     sel_q;
	logic [15:0]         key_q;
	logic [15:0]         emin_q;   // earliest pending arrival
	logic [TimeW-1:0]    run_q;

	logic [15:0]  a_i, k_i;
	logic         elig;
	logic [1:0]   pol;
	logic [TimeW-1:0] a_ext, gap;

	assign pol   = (policy == POL_RSVD) ? POL_FCFS : policy;
	assign a_i   = arr_mem[idx_q];
	assign a_ext = TimeW'(a_i);
	assign gap   = a_ext - clk_q;

	always_comb begin
		elig = !fin_q[idx_q];
		if (pol == POL_FCFS) k_i = a_i;
		else begin
			if (a_ext > clk_q) elig = 1'b0;
			k_i = (pol == POL_SJF) ? bur_mem[idx_q] : rem_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CntW'(MaxTasks)) begin
			id_mem[count_q[IdxW-1:0]]  <= task_id;
			arr_mem[count_q[IdxW-1:0]] <= arrival_time;
			bur_mem[count_q[IdxW-1:0]] <= burst_length;
		end
		if (cmd.init_copy) rem_mem[idx_q] <= bur_mem[idx_q];
		if (cmd.advance) rem_mem[sel_q] <= rem_mem[sel_q] - run_q[15:0];
		if (cmd.emit) begin
			done_task_id    <= id_mem[sel_q];
			turnaround_time <= clk_q - TimeW'(arr_mem[sel_q]);
			waiting_time    <= clk_q - TimeW'(arr_mem[sel_q]) - TimeW'(bur_mem[sel_q]);
			last_result     <= (ndone_q + 1'b1) == count_q;
			overflow        <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q      <= '0;
			count_q    <= '0;
			ndone_q    <= '0;
			idx_q      <= '0;
			clk_q      <= '0;
			drop_q     <= 1'b0;
			sel_v_q    <= 1'b0;
			sel_q      <= '0;
			key_q      <= '0;
			emin_q     <= '0;
			run_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.emit) begin
				out_valid    <= 1'b1;
				fin_q[sel_q] <= 1'b1;
				ndone_q      <= ndone_q + 1'b1;
			end
			if (cmd.load) begin
				if (count_q < CntW'(MaxTasks)) count_q <= count_q + 1'b1;
				else drop_q <= 1'b1;
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.scan_clr) begin
				sel_v_q <= 1'b0;
				emin_q  <= 16'hFFFF;
			end
			if (cmd.scan_step) begin
				if (!fin_q[idx_q] && a_i < emin_q) emin_q <= a_i;
				if (elig && (!sel_v_q || k_i < key_q)) begin
					sel_v_q <= 1'b1;
					sel_q   <= idx_q;
					key_q   <= k_i;
				end
			end
			if (cmd.idle_jump) clk_q <= TimeW'(emin_q);
			if (cmd.seed) begin
				// align clock to arrival, seed run with remaining
				if (clk_q < TimeW'(arr_mem[sel_q])) clk_q <= TimeW'(arr_mem[sel_q]);
				run_q <= TimeW'(rem_mem[sel_q]);
			end
			if (cmd.rscan_step && pol == POL_STCF && !fin_q[idx_q] && a_ext > clk_q
					&& gap < run_q) begin
				run_q <= gap;
			end
			if (cmd.advance) clk_q <= clk_q + run_q;
			if (cmd.batch_clr) begin
				fin_q   <= '0;
				count_q <= '0;
				ndone_q <= '0;
				clk_q   <= '0;
				drop_q  <= 1'b0;
			end
		end
	end

	always_comb begin
		stat          = '0;
		stat.idx_last = (CntW'(idx_q) + 1'b1) >= count_q;
		stat.have_sel = sel_v_q;
		stat.sel_done = (TimeW'(rem_mem[sel_q]) == run_q);
		stat.all_done = ndone_q == count_q;
		stat.empty    = count_q == '0;
		stat.out_busy = out_valid;
	end
endmodule

### design/cpu_schedule_simulator.sv
// Sequence: after the last task word the bursts are copied to remaining; each
// completion passes scan, pick, run scan, advance, emit and step; an idle jump adds
// a jump and a rescan, an STCF preemption repeats scan to advance; a held output
// word delays emit. Throughput: one task word per cycle while loading; input is held
// off until the batch has emitted its last result.
// Reset: arst_n clears control, counts and policy (FCFS); stores are not reset.
// ----------------------------------------------------------------------------
// cpu_schedule_simulator
// FCFS / SJF / STCF single-CPU schedule simulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpu_schedule_simulator
	import css_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       task_id,
	input  logic [15:0]      arrival_time,
	input  logic [15:0]      burst_length,
	input  logic             last_task,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       done_task_id,
	output logic [TimeW-1:0] waiting_time,
	output logic [TimeW-1:0] turnaround_time,
	output logic             last_result,
	output logic             overflow
);
	logic [1:0] policy_q;
	css_cmd_t   cmd;
	css_stat_t  stat;

	// policy register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) policy_q <= POL_FCFS;
		else if (cfg_we) policy_q <= cfg_wdata;
	end

	css_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(last_task),
		.in_ready(in_ready), .stat(stat), .cmd(cmd)
	);

	css_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .policy(policy_q),
		.task_id(task_id), .arrival_time(arrival_time), .burst_length(burst_length),
		.out_valid(out_valid), .out_ready(out_ready), .done_task_id(done_task_id),
		.waiting_time(waiting_time), .turnaround_time(turnaround_time),
		.last_result(last_result), .overflow(overflow)
	);
endmodule

### design/css_checker.sv
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks on the simulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu_schedule_simulator_assert.svh"
module css_checker
	import css_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [TimeW-1:0] waiting_time,
	input logic [TimeW-1:0] turnaround_time
);
	`CSS_ASSERT_IMPL(a_wait_le_turn, clk, arst_n, out_valid, waiting_time <= turnaround_time)
	`CSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CSS_ASSERT_NEXT(a_wait_hold, clk, arst_n, out_valid && !out_ready, $stable(waiting_time))
endmodule

bind cpu_schedule_simulator css_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_ready(out_ready), .waiting_time(waiting_time),
	.turnaround_time(turnaround_time)
);
